// ===== rtl/core/m3i_pkg.sv =====
// shared types, widths and index helpers for the 3x3 matrix inverter
package m3i_pkg;

  localparam int ENT_W   = 16;
  localparam int N_ENT   = 9;
  localparam int PROD_W  = 32;
  localparam int ADJ_W   = 33;
  localparam int DET_W   = 49;
  localparam int MAG_W   = 48;
  localparam int Q_W     = 18;
  localparam int FRAC_SH = 16;
  localparam int DV_W    = 32;
  localparam int DET_SH  = 8;
  localparam int COF_LAT = 4;
  localparam int DIV_LAT = Q_W + 1;
  localparam int TOT_LAT = COF_LAT + DIV_LAT;
  localparam int IN_W    = N_ENT * ENT_W;
  localparam int OUT_W   = N_ENT * ENT_W + DV_W;

  typedef logic signed [ENT_W-1:0] ent_t;
  typedef ent_t [N_ENT-1:0] mat_t;
  typedef logic signed [ADJ_W-1:0] adj_t;
  typedef adj_t [N_ENT-1:0] adjv_t;
  typedef logic signed [DET_W-1:0] det_t;
  typedef logic signed [DV_W-1:0] dv_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           neg;
  } lane_res_t;

  typedef lane_res_t [N_ENT-1:0] lane_vec_t;

  function automatic int oth_lo(input int k);
    return (k == 0) ? 1 : 0;
  endfunction

  function automatic int oth_hi(input int k);
    return (k == 2) ? 1 : 2;
  endfunction

endpackage

// ===== rtl/core/m3i_cofactor.sv =====
// adjugate and determinant pipeline, four register stages
module m3i_cofactor (
  input  logic          clk,
  input  logic          en,
  input  m3i_pkg::mat_t a_i,
  output m3i_pkg::adjv_t adj_o,
  output m3i_pkg::det_t det_o
);
  import m3i_pkg::*;

  mat_t a_r;
  logic signed [PROD_W-1:0] p_r [N_ENT];
  logic signed [PROD_W-1:0] q_r [N_ENT];
  logic signed [PROD_W-1:0] p_nxt [N_ENT];
  logic signed [PROD_W-1:0] q_nxt [N_ENT];
  mat_t a_b_r;
  adjv_t adj_b_r, adj_b_nxt;
  adjv_t adj_c_r, adj_d_r;
  det_t t_r [3];
  det_t t_nxt [3];
  det_t det_r;

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int R0 = oth_lo(j);
      localparam int R1 = oth_hi(j);
      localparam int C0 = oth_lo(i);
      localparam int C1 = oth_hi(i);
      localparam int K  = i * 3 + j;
      always_comb begin
        p_nxt[K] = ent_t'(a_i[R0*3+C0]) * ent_t'(a_i[R1*3+C1]);
        q_nxt[K] = ent_t'(a_i[R0*3+C1]) * ent_t'(a_i[R1*3+C0]);
      end
      always_comb begin
        if (((i + j) % 2) == 0) begin
          adj_b_nxt[K] = ADJ_W'(p_r[K]) - ADJ_W'(q_r[K]);
        end else begin
          adj_b_nxt[K] = ADJ_W'(q_r[K]) - ADJ_W'(p_r[K]);
        end
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_det
    always_comb begin
      t_nxt[j] = ent_t'(a_b_r[j]) * adj_t'(adj_b_r[j*3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= a_i;
      p_r     <= p_nxt;
      q_r     <= q_nxt;
      a_b_r   <= a_r;
      adj_b_r <= adj_b_nxt;
      t_r     <= t_nxt;
      adj_c_r <= adj_b_r;
      det_r   <= t_r[0] + t_r[1] + t_r[2];
      adj_d_r <= adj_c_r;
    end
  end

  assign adj_o = adj_d_r;
  assign det_o = det_r;

endmodule

// ===== rtl/core/m3i_div_lane.sv =====
// one pipelined restoring divider lane, one quotient bit per stage
module m3i_div_lane (
  input  logic              clk,
  input  logic              en,
  input  m3i_pkg::adj_t     adj_i,
  input  m3i_pkg::det_t     det_i,
  output m3i_pkg::lane_res_t res_o
);
  import m3i_pkg::*;

  localparam int CMP_W = MAG_W + Q_W;

  logic [MAG_W-1:0] rem_r [Q_W+1];
  logic [MAG_W-1:0] den_r [Q_W+1];
  logic [Q_W-1:0]   q_r   [Q_W+1];
  logic             neg_r [Q_W+1];
  adj_t adj_mag;
  det_t det_mag;

  always_comb begin
    adj_mag = adj_i[ADJ_W-1] ? -adj_i : adj_i;
    det_mag = det_i[DET_W-1] ? -det_i : det_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {adj_mag[MAG_W-FRAC_SH-1:0], {FRAC_SH{1'b0}}};
      den_r[0] <= det_mag[MAG_W-1:0];
      q_r[0]   <= '0;
      neg_r[0] <= adj_i[ADJ_W-1] ^ det_i[DET_W-1];
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    localparam int K = Q_W - 1 - i;
    logic [CMP_W-1:0] sh;
    logic [CMP_W-1:0] rz;
    logic [CMP_W-1:0] diff;
    logic             ge;
    logic [MAG_W-1:0] rem_nxt;
    logic [Q_W-1:0]   q_nxt;
    always_comb begin
      sh      = {{Q_W{1'b0}}, den_r[i]} << K;
      rz      = {{Q_W{1'b0}}, rem_r[i]};
      diff    = rz - sh;
      ge      = (rz >= sh);
      rem_nxt = ge ? diff[MAG_W-1:0] : rem_r[i];
      q_nxt   = q_r[i];
      q_nxt[K] = ge;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= rem_nxt;
        den_r[i+1] <= den_r[i];
        q_r[i+1]   <= q_nxt;
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  assign res_o.q   = q_r[Q_W];
  assign res_o.neg = neg_r[Q_W];

endmodule

// ===== rtl/core/m3i_merge.sv =====
// merges lane quotients: sign, saturation, determinant scaling, singular select
module m3i_merge (
  input  m3i_pkg::lane_vec_t lanes_i,
  input  m3i_pkg::det_t      det_i,
  input  m3i_pkg::mat_t      echo_i,
  output m3i_pkg::mat_t      r_o,
  output m3i_pkg::dv_t       dv_o,
  output logic               sing_o
);
  import m3i_pkg::*;

  localparam logic [Q_W-2:0] POS_MAX = {2'b00, {(ENT_W-1){1'b1}}};
  localparam logic [Q_W-2:0] NEG_MAX = {2'b01, {(ENT_W-1){1'b0}}};
  localparam logic [MAG_W-DET_SH-1:0] DV_PMAX = {{(MAG_W-DET_SH-DV_W+1){1'b0}},
                                                 {(DV_W-1){1'b1}}};
  localparam logic [MAG_W-DET_SH-1:0] DV_NMAX = DV_PMAX + 1'b1;

  mat_t r_div;
  det_t det_mag;
  logic [MAG_W-DET_SH-1:0] dsh;
  logic [MAG_W-DET_SH-1:0] dneg;
  dv_t  dv;

  for (genvar k = 0; k < N_ENT; k++) begin : g_lane
    logic [Q_W-2:0] mag;
    logic [Q_W-2:0] nmag;
    always_comb begin
      mag  = lanes_i[k].q[Q_W-2:0];
      nmag = -mag;
      if (lanes_i[k].neg) begin
        if (lanes_i[k].q[Q_W-1] || (mag > NEG_MAX)) begin
          r_div[k] = ent_t'(NEG_MAX[ENT_W-1:0]);
        end else begin
          r_div[k] = ent_t'(nmag[ENT_W-1:0]);
        end
      end else begin
        if (lanes_i[k].q[Q_W-1] || (mag > POS_MAX)) begin
          r_div[k] = ent_t'(POS_MAX[ENT_W-1:0]);
        end else begin
          r_div[k] = ent_t'(mag[ENT_W-1:0]);
        end
      end
    end
  end

  always_comb begin
    det_mag = det_i[DET_W-1] ? -det_i : det_i;
    dsh     = det_mag[MAG_W-1:DET_SH];
    dneg    = -dsh;
    if (det_i[DET_W-1]) begin
      dv = (dsh > DV_NMAX) ? dv_t'(DV_NMAX[DV_W-1:0]) : dv_t'(dneg[DV_W-1:0]);
    end else begin
      dv = (dsh > DV_PMAX) ? dv_t'(DV_PMAX[DV_W-1:0]) : dv_t'(dsh[DV_W-1:0]);
    end
    sing_o = (det_i == '0);
    r_o    = sing_o ? echo_i : r_div;
    dv_o   = sing_o ? '0 : dv;
  end

endmodule

// ===== rtl/core/matrix3x3_inverse.sv =====
// top level of the pipelined 3x3 matrix inverter
//
// in channel: one 3x3 matrix of signed Q8.8 entries per transfer on in_tdata
// out channel: the nine inverse entries (Q8.8, saturated) and the Q16.16
//   determinant on out_tdata, singular flag on out_tuser
// a singular matrix returns its own entries with a zero determinant
// from an input transfer to out_tvalid, the cofactor stages form the adjugate
//   and determinant, the nine divider lanes run side by side (one quotient bit
//   per stage), and the output register holds the result
// throughput: one matrix per cycle while out_tready stays high
// when the receiver stalls the whole pipeline holds and in_tready drops;
//   in_tready is high whenever the output register is empty or being taken
// reset clears all valid bits; no result is lost or repeated across stalls
// the divider lanes set the depth: 18 quotient bits plus one load stage
module matrix3x3_inverse (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // a00, a01, a02, a10, a11, a12, a20, a21, a22
  input  logic [m3i_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22, det_value
  output logic [m3i_pkg::OUT_W-1:0] out_tdata,
  // singular
  output logic                      out_tuser
);
  import m3i_pkg::*;

  logic      en;
  logic      v_r [TOT_LAT];
  mat_t      e_r [TOT_LAT];
  det_t      d_r [DIV_LAT];
  adjv_t     adj;
  det_t      det;
  lane_vec_t lanes;
  mat_t      r_m;
  dv_t       dv_m;
  logic      sing_m;
  logic      out_tvalid_r;
  mat_t      out_r_r;
  dv_t       out_dv_r;
  logic      out_sing_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  m3i_cofactor u_cof (
    .clk   (clk),
    .en    (en),
    .a_i   (mat_t'(in_tdata)),
    .adj_o (adj),
    .det_o (det)
  );

  for (genvar k = 0; k < N_ENT; k++) begin : g_lane
    m3i_div_lane u_lane (
      .clk   (clk),
      .en    (en),
      .adj_i (adj[k]),
      .det_i (det),
      .res_o (lanes[k])
    );
  end

  m3i_merge u_merge (
    .lanes_i (lanes),
    .det_i   (d_r[DIV_LAT-1]),
    .echo_i  (e_r[TOT_LAT-1]),
    .r_o     (r_m),
    .dv_o    (dv_m),
    .sing_o  (sing_m)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOT_LAT; i++) begin
        v_r[i] <= 1'b0;
      end
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid;
      for (int i = 1; i < TOT_LAT; i++) begin
        v_r[i] <= v_r[i-1];
      end
      out_tvalid_r <= v_r[TOT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= mat_t'(in_tdata);
      for (int i = 1; i < TOT_LAT; i++) begin
        e_r[i] <= e_r[i-1];
      end
      d_r[0] <= det;
      for (int i = 1; i < DIV_LAT; i++) begin
        d_r[i] <= d_r[i-1];
      end
      out_r_r    <= r_m;
      out_dv_r   <= dv_m;
      out_sing_r <= sing_m;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_dv_r, out_r_r};
  assign out_tuser  = out_sing_r;

endmodule

// ===== rtl/core/m3i_checker.sv =====
// port-level checks for the matrix inverter, bound to the top level
module m3i_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [m3i_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tuser
);
  import m3i_pkg::*;

  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid after reset");

  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output stage");

  a_sing_det: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[OUT_W-1:OUT_W-DV_W] == '0)
    else $error("singular result with nonzero determinant");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
